// ----- rtl/core/keyframe_rotation_interpolator_assert.svh -----
// ----------------------------------------------------------------------------
// Keyframe rotation interpolator assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_ROTATION_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_ROTATION_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define KRI_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keyframe rotation interpolator: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define KRI_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keyframe rotation interpolator: next-cycle check failed");
`else
`define KRI_ASSERT_IMP(label, ante, cons)
`define KRI_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- rtl/core/kri_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kri_pkg
// Shared constants, types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package kri_pkg;

   localparam int MAX_KEYS = 16;
   localparam int IDX_W    = $clog2(MAX_KEYS);
   localparam int CNT_W    = IDX_W + 1;
   localparam int KEY_W    = 32;
   localparam int AXIS_W   = 18;
   localparam int ANG_W    = 20;
   localparam int OANG_W   = 19;
   localparam int BAX_W    = AXIS_W + 1;
   localparam int WIDE_W   = 23;
   localparam int T_W      = 17;
   localparam int PROD_W   = WIDE_W + BAX_W;
   localparam int DOT_W    = 38;
   localparam int SUM_W    = 28;

   localparam logic [CNT_W-1:0]         MAX_KEYS_C = CNT_W'(MAX_KEYS);
   localparam logic signed [WIDE_W-1:0] PI_Q       = 23'sd205887;
   localparam logic signed [WIDE_W-1:0] TWO_PI_Q   = 23'sd411775;
   localparam logic signed [AXIS_W-1:0] AXIS_ONE   = 18'sd65536;
   localparam logic signed [SUM_W-1:0]  AXIS_MAX   = 28'sd131071;
   localparam logic signed [SUM_W-1:0]  AXIS_MIN   = -28'sd131072;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = 42'sd32768;

   // One key table entry.
   typedef struct packed {
      logic signed [KEY_W-1:0]  key;
      logic signed [AXIS_W-1:0] ax;
      logic signed [AXIS_W-1:0] ay;
      logic signed [AXIS_W-1:0] az;
      logic signed [ANG_W-1:0]  ang;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_ENDS, ST_SEG, ST_DIV, ST_BLEND, ST_DOT,
      ST_NEG, ST_ANGLE, ST_LERP, ST_WRAP, ST_RESULT
   } state_type;

   typedef enum logic [2:0] {
      MUL_DX, MUL_DY, MUL_DZ, MUL_LX, MUL_LY, MUL_LZ, MUL_LA
   } mul_sel_type;

   typedef enum logic [1:0] {
      ELEM_X, ELEM_Y, ELEM_Z, ELEM_ANG
   } elem_type;

   typedef enum logic [1:0] {
      AXIS_FROM_A, AXIS_FROM_B, AXIS_MIX
   } axis_mode_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             capture;
      logic             rd_en;
      logic [IDX_W-1:0] rd_a;
      logic [IDX_W-1:0] rd_b;
      logic             set_default;
      logic             take_end;
      logic             take_b;
      logic             div_init;
      logic             div_step;
      logic             blend_init;
      logic             mul_en;
      mul_sel_type      mul_sel;
      logic             acc_en;
      logic             neg_apply;
      logic             ang_adjust;
      logic             fin_en;
      elem_type         fin_sel;
      logic             wrap_step;
      logic             commit;
      logic             out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic f_below_a;
      logic f_above_b;
      logic wrap_ok;
      logic ang_a_zero;
      logic ang_b_zero;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/core/keyframe_rotation_interpolator.sv -----
`timescale 1ns / 1ps
// Load transactions produce no result.
// Evaluate steps: an empty table gives the default rotation, a fraction outside the keys
// is clamped to an end entry, and inside the keys the segment scan, the one-bit-a-cycle
// divider and the blend steps run in order.
// One evaluate transaction is worked on at a time; a new one is taken while a result waits.
// Reset clears the key count and sets the held rotation to (0,0,1,0); table is not cleared.
// ----------------------------------------------------------------------------
// keyframe_rotation_interpolator
// Top level: stream packing, controller and datapath.
// ----------------------------------------------------------------------------
module keyframe_rotation_interpolator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [3:0] entry_index, [35:4] key_position, [67:36] fraction, [85:68] axis_x,
   // [103:86] axis_y, [121:104] axis_z, [141:122] angle, [143:142] zero
   input  logic [143:0] req_tdata,
   // [0] cmd
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [17:0] out_axis_x, [35:18] out_axis_y, [53:36] out_axis_z,
   // [72:54] out_angle, [79:73] zero
   output logic [79:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [4:0]   csr_wdata
);
   import kri_pkg::*;

   cmd_type                  cmd_w;
   status_type               sts_w;
   logic signed [AXIS_W-1:0] out_x_w, out_y_w, out_z_w;
   logic [OANG_W-1:0]        out_ang_w;

   // Sequencer.
   kri_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .cmd_o      (cmd_w),
      .sts_i      (sts_w)
   );

   // Table and arithmetic.
   kri_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd_i            (cmd_w),
      .sts_o            (sts_w),
      .req_cmd          (req_tuser),
      .req_entry_index  (req_tdata[3:0]),
      .req_key_position (req_tdata[35:4]),
      .req_fraction     (req_tdata[67:36]),
      .req_axis_x       (req_tdata[85:68]),
      .req_axis_y       (req_tdata[103:86]),
      .req_axis_z       (req_tdata[121:104]),
      .req_angle        (req_tdata[141:122]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_out_axis_x   (out_x_w),
      .rsp_out_axis_y   (out_y_w),
      .rsp_out_axis_z   (out_z_w),
      .rsp_out_angle    (out_ang_w)
   );

   assign rsp_tdata = {7'b0, out_ang_w, out_z_w, out_y_w, out_x_w};

endmodule

// ----- rtl/core/kri_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kri_datapath
// Key table, radix-2 divider, shared multiplier, blend and wrap registers,
// last-rotation state and the result output register.
// ----------------------------------------------------------------------------
module kri_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  kri_pkg::cmd_type                   cmd_i,
   output kri_pkg::status_type                sts_o,
   input  logic                               req_cmd,
   input  logic [kri_pkg::IDX_W-1:0]          req_entry_index,
   input  logic signed [kri_pkg::KEY_W-1:0]   req_key_position,
   input  logic signed [kri_pkg::KEY_W-1:0]   req_fraction,
   input  logic signed [kri_pkg::AXIS_W-1:0]  req_axis_x,
   input  logic signed [kri_pkg::AXIS_W-1:0]  req_axis_y,
   input  logic signed [kri_pkg::AXIS_W-1:0]  req_axis_z,
   input  logic signed [kri_pkg::ANG_W-1:0]   req_angle,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic signed [kri_pkg::AXIS_W-1:0]  rsp_out_axis_x,
   output logic signed [kri_pkg::AXIS_W-1:0]  rsp_out_axis_y,
   output logic signed [kri_pkg::AXIS_W-1:0]  rsp_out_axis_z,
   output logic [kri_pkg::OANG_W-1:0]         rsp_out_angle
);
   import kri_pkg::*;

   entry_type                key_mem [MAX_KEYS];
   entry_type                ent_a_ff, ent_b_ff, wr_entry;
   logic signed [KEY_W-1:0]  frac_ff;
   logic [KEY_W-1:0]         num_w, den_w, den_ff, rem_ff;
   logic [KEY_W:0]           rem2_w;
   logic [T_W-1:0]           q_ff, t_w;
   logic                     zero_ff;
   logic signed [BAX_W-1:0]  bx_ff, by_ff, bz_ff;
   logic signed [WIDE_W-1:0] r1_ff, r2_ff, ang_d_w;
   axis_mode_type            mode_ff;
   logic signed [WIDE_W-1:0] op_a_w, a_val_w;
   logic signed [BAX_W-1:0]  op_b_w;
   logic signed [PROD_W-1:0] mul_ff, rnd_w;
   logic signed [DOT_W-1:0]  dot_ff;
   logic signed [SUM_W-1:0]  sum_w;
   logic signed [AXIS_W-1:0] sat_w;
   logic signed [AXIS_W-1:0] res_x_ff, res_y_ff, res_z_ff;
   logic signed [WIDE_W-1:0] res_ang_ff;
   logic signed [AXIS_W-1:0] last_x_ff, last_y_ff, last_z_ff;
   logic [OANG_W-1:0]        last_ang_ff;
   logic                     rsp_valid_ff;
   logic signed [AXIS_W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic [OANG_W-1:0]        out_ang_ff;
   entry_type                end_w;
   logic signed [AXIS_W-1:0] fix_a_w, fix_b_w;

   assign wr_entry = '{key: req_key_position, ax: req_axis_x, ay: req_axis_y,
                       az: req_axis_z, ang: req_angle};

   // Key table: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (cmd_i.capture && !req_cmd) begin
         key_mem[req_entry_index] <= wr_entry;
      end
      if (cmd_i.rd_en) begin
         ent_a_ff <= key_mem[cmd_i.rd_a];
         ent_b_ff <= key_mem[cmd_i.rd_b];
      end
      if (cmd_i.capture) begin
         frac_ff <= req_fraction;
      end
   end

   // Segment compares.
   assign sts_o.f_below_a  = frac_ff < ent_a_ff.key;
   assign sts_o.f_above_b  = frac_ff > ent_b_ff.key;
   assign sts_o.ang_a_zero = ent_a_ff.ang == '0;
   assign sts_o.ang_b_zero = ent_b_ff.ang == '0;

   // Restoring divider for the local factor, one quotient bit a cycle.
   assign num_w  = KEY_W'(frac_ff - ent_a_ff.key);
   assign den_w  = KEY_W'(ent_b_ff.key - ent_a_ff.key);
   assign rem2_w = {rem_ff, 1'b0};
   assign t_w    = zero_ff ? '0 : q_ff;

   always_ff @(posedge clock) begin
      if (cmd_i.div_init) begin
         den_ff  <= den_w;
         zero_ff <= den_w == '0;
         if (num_w >= den_w) begin
            rem_ff <= num_w - den_w;
            q_ff   <= T_W'(1);
         end else begin
            rem_ff <= num_w;
            q_ff   <= '0;
         end
      end else if (cmd_i.div_step) begin
         if (rem2_w >= {1'b0, den_ff}) begin
            rem_ff <= KEY_W'(rem2_w - {1'b0, den_ff});
            q_ff   <= {q_ff[T_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem2_w[KEY_W-1:0];
            q_ff   <= {q_ff[T_W-2:0], 1'b0};
         end
      end
   end

   // Shared multiplier operand selection.
   always_comb begin
      case (cmd_i.mul_sel)
         MUL_DX: begin
            op_a_w = WIDE_W'(ent_a_ff.ax);
            op_b_w = bx_ff;
         end
         MUL_DY: begin
            op_a_w = WIDE_W'(ent_a_ff.ay);
            op_b_w = by_ff;
         end
         MUL_DZ: begin
            op_a_w = WIDE_W'(ent_a_ff.az);
            op_b_w = bz_ff;
         end
         MUL_LX: begin
            op_a_w = WIDE_W'(bx_ff) - WIDE_W'(ent_a_ff.ax);
            op_b_w = {2'b00, t_w};
         end
         MUL_LY: begin
            op_a_w = WIDE_W'(by_ff) - WIDE_W'(ent_a_ff.ay);
            op_b_w = {2'b00, t_w};
         end
         MUL_LZ: begin
            op_a_w = WIDE_W'(bz_ff) - WIDE_W'(ent_a_ff.az);
            op_b_w = {2'b00, t_w};
         end
         MUL_LA: begin
            op_a_w = r2_ff - r1_ff;
            op_b_w = {2'b00, t_w};
         end
         default: begin
            op_a_w = '0;
            op_b_w = '0;
         end
      endcase
   end

   // Lerp finishing: round the product and add the start value.
   always_comb begin
      case (cmd_i.fin_sel)
         ELEM_X:   begin a_val_w = WIDE_W'(ent_a_ff.ax); fix_a_w = ent_a_ff.ax;
                         fix_b_w = ent_b_ff.ax; end
         ELEM_Y:   begin a_val_w = WIDE_W'(ent_a_ff.ay); fix_a_w = ent_a_ff.ay;
                         fix_b_w = ent_b_ff.ay; end
         ELEM_Z:   begin a_val_w = WIDE_W'(ent_a_ff.az); fix_a_w = ent_a_ff.az;
                         fix_b_w = ent_b_ff.az; end
         default:  begin a_val_w = r1_ff; fix_a_w = '0; fix_b_w = '0; end
      endcase
   end

   assign rnd_w = (mul_ff + ROUND_HALF) >>> 16;
   assign sum_w = SUM_W'(a_val_w) + rnd_w[SUM_W-1:0];

   always_comb begin
      if (sum_w > AXIS_MAX) begin
         sat_w = AXIS_MAX[AXIS_W-1:0];
      end else if (sum_w < AXIS_MIN) begin
         sat_w = AXIS_MIN[AXIS_W-1:0];
      end else begin
         sat_w = sum_w[AXIS_W-1:0];
      end
   end

   assign ang_d_w = r2_ff - r1_ff;
   assign end_w   = cmd_i.take_b ? ent_b_ff : ent_a_ff;

   // Blend working registers: multiplier, dot product, angles and results.
   always_ff @(posedge clock) begin
      if (cmd_i.mul_en) begin
         mul_ff <= op_a_w * op_b_w;
      end
      if (cmd_i.blend_init) begin
         bx_ff  <= BAX_W'(ent_b_ff.ax);
         by_ff  <= BAX_W'(ent_b_ff.ay);
         bz_ff  <= BAX_W'(ent_b_ff.az);
         r1_ff  <= WIDE_W'(ent_a_ff.ang);
         r2_ff  <= WIDE_W'(ent_b_ff.ang);
         dot_ff <= '0;
         if (ent_b_ff.ang == '0) begin
            mode_ff <= AXIS_FROM_A;
         end else if (ent_a_ff.ang == '0) begin
            mode_ff <= AXIS_FROM_B;
         end else begin
            mode_ff <= AXIS_MIX;
         end
      end else if (cmd_i.acc_en) begin
         dot_ff <= dot_ff + mul_ff[DOT_W-1:0];
      end else if (cmd_i.neg_apply) begin
         if (dot_ff < 0) begin
            bx_ff <= -bx_ff;
            by_ff <= -by_ff;
            bz_ff <= -bz_ff;
            r2_ff <= -r2_ff;
         end
      end else if (cmd_i.ang_adjust) begin
         if (ang_d_w > PI_Q || ang_d_w < -PI_Q) begin
            if (r2_ff > r1_ff) begin
               r1_ff <= r1_ff + TWO_PI_Q;
            end else begin
               r2_ff <= r2_ff + TWO_PI_Q;
            end
         end
      end
      if (cmd_i.take_end) begin
         res_x_ff   <= end_w.ax;
         res_y_ff   <= end_w.ay;
         res_z_ff   <= end_w.az;
         res_ang_ff <= WIDE_W'(end_w.ang);
      end else if (cmd_i.fin_en) begin
         case (cmd_i.fin_sel)
            ELEM_X:  res_x_ff <= (mode_ff == AXIS_MIX) ? sat_w :
                                 (mode_ff == AXIS_FROM_A) ? fix_a_w : fix_b_w;
            ELEM_Y:  res_y_ff <= (mode_ff == AXIS_MIX) ? sat_w :
                                 (mode_ff == AXIS_FROM_A) ? fix_a_w : fix_b_w;
            ELEM_Z:  res_z_ff <= (mode_ff == AXIS_MIX) ? sat_w :
                                 (mode_ff == AXIS_FROM_A) ? fix_a_w : fix_b_w;
            default: res_ang_ff <= sum_w[WIDE_W-1:0];
         endcase
      end else if (cmd_i.wrap_step) begin
         if (res_ang_ff < 0) begin
            res_ang_ff <= res_ang_ff + TWO_PI_Q;
         end else begin
            res_ang_ff <= res_ang_ff - TWO_PI_Q;
         end
      end
   end

   assign sts_o.wrap_ok = (res_ang_ff >= 0) && (res_ang_ff < TWO_PI_Q);

   // Last rotation, held between evaluations.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff   <= '0;
         last_y_ff   <= '0;
         last_z_ff   <= AXIS_ONE;
         last_ang_ff <= '0;
      end else if (cmd_i.set_default) begin
         last_x_ff   <= '0;
         last_y_ff   <= '0;
         last_z_ff   <= AXIS_ONE;
         last_ang_ff <= '0;
      end else if (cmd_i.commit) begin
         last_x_ff   <= res_x_ff;
         last_y_ff   <= res_y_ff;
         last_z_ff   <= res_z_ff;
         last_ang_ff <= res_ang_ff[OANG_W-1:0];
      end
   end

   // Output register: the next transaction may start while a result waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_i.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.out_load) begin
         out_x_ff   <= last_x_ff;
         out_y_ff   <= last_y_ff;
         out_z_ff   <= last_z_ff;
         out_ang_ff <= last_ang_ff;
      end
   end

   assign sts_o.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_out_axis_x = out_x_ff;
   assign rsp_out_axis_y = out_y_ff;
   assign rsp_out_axis_z = out_z_ff;
   assign rsp_out_angle  = out_ang_ff;

endmodule

// ----- rtl/core/kri_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kri_controller
// Sequencer for the evaluation steps, plus the key count register.
// ----------------------------------------------------------------------------
module kri_controller (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic                       req_cmd,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [kri_pkg::CNT_W-1:0]  csr_wdata,
   output kri_pkg::cmd_type           cmd_o,
   input  kri_pkg::status_type        sts_i
);
   import kri_pkg::*;

   `include "keyframe_rotation_interpolator_assert.svh"

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] seg_ff, seg_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] kc_ff;
   logic [CNT_W-1:0] n_w, seg_next_w;
   logic             hit_w;

   assign n_w        = (kc_ff > MAX_KEYS_C) ? MAX_KEYS_C : kc_ff;
   assign seg_next_w = {1'b0, seg_ff} + CNT_W'(2);
   assign hit_w      = !sts_i.f_below_a && !sts_i.f_above_b;
   assign csr_ready  = 1'b1;

   // Key count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         kc_ff <= '0;
      end else if (csr_valid) begin
         kc_ff <= csr_wdata;
      end
   end

   // State, segment index and step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seg_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         seg_ff   <= seg_in;
         step_ff  <= step_in;
      end
   end

   assign step_in = (state_in != state_ff) ? '0 : step_ff + IDX_W'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      seg_in   = seg_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid && req_cmd) state_in = ST_START;
         ST_START:  state_in = (n_w == '0) ? ST_RESULT : ST_ENDS;
         ST_ENDS: begin
            if (sts_i.f_below_a || sts_i.f_above_b) begin
               state_in = ST_WRAP;
            end else if (n_w >= CNT_W'(2)) begin
               state_in = ST_SEG;
               seg_in   = '0;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_SEG: begin
            if (hit_w) begin
               state_in = ST_DIV;
            end else if (seg_next_w < n_w) begin
               seg_in = seg_ff + IDX_W'(1);
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_DIV:    if (step_ff == '1) state_in = ST_BLEND;
         ST_BLEND:  state_in = (sts_i.ang_a_zero || sts_i.ang_b_zero) ? ST_ANGLE : ST_DOT;
         ST_DOT:    if (step_ff == IDX_W'(3)) state_in = ST_NEG;
         ST_NEG:    state_in = ST_ANGLE;
         ST_ANGLE:  state_in = ST_LERP;
         ST_LERP:   if (step_ff == IDX_W'(4)) state_in = ST_WRAP;
         ST_WRAP:   if (sts_i.wrap_ok) state_in = ST_RESULT;
         ST_RESULT: if (sts_i.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Commands.
   always_comb begin
      cmd_o      = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd_o.capture = req_tvalid;
         end
         ST_START: begin
            if (n_w == '0) begin
               cmd_o.set_default = 1'b1;
            end else begin
               cmd_o.rd_en = 1'b1;
               cmd_o.rd_a  = '0;
               cmd_o.rd_b  = IDX_W'(n_w - CNT_W'(1));
            end
         end
         ST_ENDS: begin
            if (sts_i.f_below_a) begin
               cmd_o.take_end = 1'b1;
            end else if (sts_i.f_above_b) begin
               cmd_o.take_end = 1'b1;
               cmd_o.take_b   = 1'b1;
            end else begin
               cmd_o.rd_en = n_w >= CNT_W'(2);
               cmd_o.rd_a  = '0;
               cmd_o.rd_b  = IDX_W'(1);
            end
         end
         ST_SEG: begin
            if (hit_w) begin
               cmd_o.div_init = 1'b1;
            end else begin
               cmd_o.rd_en = seg_next_w < n_w;
               cmd_o.rd_a  = seg_ff + IDX_W'(1);
               cmd_o.rd_b  = seg_next_w[IDX_W-1:0];
            end
         end
         ST_DIV:   cmd_o.div_step   = 1'b1;
         ST_BLEND: cmd_o.blend_init = 1'b1;
         ST_DOT: begin
            cmd_o.mul_en = step_ff < IDX_W'(3);
            cmd_o.acc_en = step_ff != '0;
            case (step_ff)
               IDX_W'(0): cmd_o.mul_sel = MUL_DX;
               IDX_W'(1): cmd_o.mul_sel = MUL_DY;
               default:   cmd_o.mul_sel = MUL_DZ;
            endcase
         end
         ST_NEG:   cmd_o.neg_apply  = 1'b1;
         ST_ANGLE: cmd_o.ang_adjust = 1'b1;
         ST_LERP: begin
            cmd_o.mul_en = step_ff < IDX_W'(4);
            cmd_o.fin_en = step_ff != '0;
            case (step_ff)
               IDX_W'(0): begin cmd_o.mul_sel = MUL_LX; cmd_o.fin_sel = ELEM_X; end
               IDX_W'(1): begin cmd_o.mul_sel = MUL_LY; cmd_o.fin_sel = ELEM_X; end
               IDX_W'(2): begin cmd_o.mul_sel = MUL_LZ; cmd_o.fin_sel = ELEM_Y; end
               IDX_W'(3): begin cmd_o.mul_sel = MUL_LA; cmd_o.fin_sel = ELEM_Z; end
               default:   begin cmd_o.mul_sel = MUL_LA; cmd_o.fin_sel = ELEM_ANG; end
            endcase
         end
         ST_WRAP: begin
            cmd_o.commit    = sts_i.wrap_ok;
            cmd_o.wrap_step = !sts_i.wrap_ok;
         end
         ST_RESULT: cmd_o.out_load = sts_i.out_free;
         default: begin
            cmd_o = '0;
         end
      endcase
   end

   // A result is never loaded over one that has not been taken.
   `KRI_ASSERT_IMP(a_out_load_free, cmd_o.out_load, sts_i.out_free)
   // The committed angle is always inside the wrapped range.
   `KRI_ASSERT_IMP(a_commit_wrapped, cmd_o.commit, sts_i.wrap_ok)
   // The segment scan never reads past the last valid key.
   `KRI_ASSERT_IMP(a_seg_bound, state_ff == ST_SEG, seg_next_w <= n_w)
   // An accepted evaluate transaction always starts the sequence.
   `KRI_ASSERT_NXT(a_eval_starts, state_ff == ST_IDLE && req_tvalid && req_cmd,
                   state_ff == ST_START)

endmodule

// ----- verif/keyframe_rotation_interpolator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_rotation_interpolator_tb
// Loads key tables and evaluates fractions against the interpolator. A
// predictor inside a small scoreboard class works out each rotation, and
// every result transaction is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module keyframe_rotation_interpolator_tb;
   import kri_pkg::*;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;
   localparam int   SETTLE_CYCLES = 64;
   localparam longint CYCLE_LIMIT = 1500000;

   typedef struct {
      logic [17:0] x;
      logic [17:0] y;
      logic [17:0] z;
      logic [18:0] ang;
   } rotation_t;

   // Predictor of the interpolator and the queue of rotations still awaited.
   class rotation_scoreboard;
      longint key_tab[16], ax_tab[16], ay_tab[16], az_tab[16], ang_tab[16];
      longint held_x, held_y, held_z, held_ang;
      int unsigned key_count;
      rotation_t pending_rot[$];
      int errors, loads, evals, checked;

      function new();
         held_x = 0; held_y = 0; held_z = 65536; held_ang = 0;
         key_count = 0;
      endfunction

      function longint round_q16(longint p);
         longint q;
         q = p + 32768;
         if (q >= 0) return q / 65536;
         return -((-q + 65535) / 65536);
      endfunction

      function longint sat18(longint v);
         if (v > 131071) return 131071;
         if (v < -131072) return -131072;
         return v;
      endfunction

      function longint wrap_ang(longint r);
         longint m;
         m = r % longint'(TWO_PI_Q);
         if (m < 0) m += longint'(TWO_PI_Q);
         return m;
      endfunction

      function longint mix(longint a, longint b, longint t);
         return a + round_q16(t * (b - a));
      endfunction

      function void take_key(int k);
         held_x = ax_tab[k]; held_y = ay_tab[k]; held_z = az_tab[k];
         held_ang = wrap_ang(ang_tab[k]);
      endfunction

      // Blend between entries a and b with the local factor t.
      function void blend(int a, int b, longint t);
         longint r1, r2, bx, by, bz, dot, d;
         r1 = ang_tab[a];
         r2 = ang_tab[b];
         if (r2 == 0) begin
            held_x = ax_tab[a]; held_y = ay_tab[a]; held_z = az_tab[a];
         end else if (r1 == 0) begin
            held_x = ax_tab[b]; held_y = ay_tab[b]; held_z = az_tab[b];
         end else begin
            bx = ax_tab[b]; by = ay_tab[b]; bz = az_tab[b];
            dot = ax_tab[a] * bx + ay_tab[a] * by + az_tab[a] * bz;
            if (dot < 0) begin
               bx = -bx; by = -by; bz = -bz; r2 = -r2;
            end
            held_x = sat18(mix(ax_tab[a], bx, t));
            held_y = sat18(mix(ay_tab[a], by, t));
            held_z = sat18(mix(az_tab[a], bz, t));
         end
         d = r2 - r1;
         if (d > longint'(PI_Q) || d < -longint'(PI_Q)) begin
            if (r2 > r1) r1 += longint'(TWO_PI_Q);
            else r2 += longint'(TWO_PI_Q);
         end
         held_ang = wrap_ang(mix(r1, r2, t));
      endfunction

      function void evaluate(longint f);
         int n;
         longint num, den, t;
         n = (key_count > 16) ? 16 : key_count;
         if (n == 0) begin
            held_x = 0; held_y = 0; held_z = 65536; held_ang = 0;
            return;
         end
         if (f < key_tab[0]) begin
            take_key(0);
            return;
         end
         if (f > key_tab[n-1]) begin
            take_key(n - 1);
            return;
         end
         // The first matching segment wins; no match keeps the held rotation.
         for (int i = 0; i + 1 < n; i++) begin
            if (key_tab[i] <= f && f <= key_tab[i+1]) begin
               num = f - key_tab[i];
               den = key_tab[i+1] - key_tab[i];
               t = (den == 0) ? 0 : (num <<< 16) / den;
               blend(i, i + 1, t);
               return;
            end
         end
      endfunction

      // Notes one accepted request transaction.
      function void note_request(logic cmd, logic [3:0] idx, logic signed [31:0] key,
                                 logic signed [31:0] frac, logic signed [17:0] x,
                                 logic signed [17:0] y, logic signed [17:0] z,
                                 logic signed [19:0] ang);
         rotation_t r;
         if (cmd == CMD_LOAD) begin
            key_tab[idx] = key; ax_tab[idx] = x; ay_tab[idx] = y;
            az_tab[idx] = z; ang_tab[idx] = ang;
            loads++;
            return;
         end
         evaluate(frac);
         r.x = held_x[17:0]; r.y = held_y[17:0]; r.z = held_z[17:0];
         r.ang = held_ang[18:0];
         pending_rot.push_back(r);
         evals++;
      endfunction

      // Checks one accepted result transaction against the oldest expectation.
      function void check_result(logic [79:0] d);
         rotation_t r;
         if (pending_rot.size() == 0) begin
            $error("unexpected result transaction: %h", d);
            errors++;
            return;
         end
         r = pending_rot.pop_front();
         checked++;
         if (d[17:0] !== r.x) begin
            $error("out_axis_x: expected %0d, got %0d", $signed(r.x), $signed(d[17:0]));
            errors++;
         end
         if (d[35:18] !== r.y) begin
            $error("out_axis_y: expected %0d, got %0d", $signed(r.y), $signed(d[35:18]));
            errors++;
         end
         if (d[53:36] !== r.z) begin
            $error("out_axis_z: expected %0d, got %0d", $signed(r.z), $signed(d[53:36]));
            errors++;
         end
         if (d[72:54] !== r.ang) begin
            $error("out_angle: expected %0d, got %0d", r.ang, d[72:54]);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [4:0]   csr_wdata = '0;

   rotation_scoreboard sb = new();
   int     tx_idle_pct = 32;
   int     rx_idle_pct = 83;
   int     cfg_writes = 0;
   longint cycles = 0;
   longint seq_key[16];

   keyframe_rotation_interpolator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // Cycle counter with the run timeout.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("keyframe_rotation_interpolator_tb: done, errors");
         $finish;
      end
   end

   // Result side: random back-pressure and checking of each transaction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Sends one request transaction and notes it once accepted.
   task automatic send_request(logic cmd, logic [3:0] idx, logic [31:0] key,
                               logic [31:0] frac, logic [17:0] x, logic [17:0] y,
                               logic [17:0] z, logic [19:0] ang);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, ang, z, y, x, frac, key, idx};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, idx, key, frac, x, y, z, ang);
   endtask

   task automatic load_entry(logic [3:0] idx, logic [31:0] key, logic [17:0] x,
                             logic [17:0] y, logic [17:0] z, logic [19:0] ang);
      send_request(CMD_LOAD, idx, key, $urandom, x, y, z, ang);
   endtask

   task automatic eval_fraction(logic [31:0] frac);
      send_request(CMD_EVAL, $urandom, $urandom, frac, $urandom, $urandom, $urandom,
                   $urandom);
   endtask

   // Writes the key count once the block has drained.
   task automatic write_key_count(logic [4:0] value);
      req_tvalid <= 1'b0;
      while (sb.pending_rot.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.key_count = value;
      cfg_writes++;
   endtask

   // Reloads all sixteen entries with non-decreasing keys and random rotations.
   task automatic load_ascending_table(output int sent);
      longint k;
      logic [19:0] ang;
      k = longint'($signed($urandom_range(4000000))) - 2000000;
      for (int i = 0; i < 16; i++) begin
         if (i > 0 && $urandom_range(9) != 0) k += $urandom_range(300000);
         seq_key[i] = k;
         ang = ($urandom_range(7) == 0) ? 20'd0 : 20'($urandom);
         load_entry(i, k[31:0], $urandom, $urandom, $urandom, ang);
      end
      sent = 16;
   endtask

   // Mostly well-formed tables with evaluations, plus some noise.
   task automatic run_phase(logic [4:0] count, int quota);
      int sent, n, j, m;
      longint f;
      write_key_count(count);
      sent = 0;
      n = (count > 16) ? 16 : count;
      while (sent < quota) begin
         if ($urandom_range(9) < 7) begin
            load_ascending_table(m);
            sent += m;
            repeat ($urandom_range(12, 24)) begin
               j = (n == 0) ? 0 : $urandom_range(n - 1);
               case ($urandom_range(9))
                  0: f = seq_key[0] - $urandom_range(1, 100000);
                  1: f = seq_key[(n == 0) ? 0 : n - 1] + $urandom_range(1, 100000);
                  2: f = seq_key[j];
                  default: f = seq_key[j] + $urandom_range(300000);
               endcase
               eval_fraction(f[31:0]);
               sent++;
            end
         end else begin
            repeat ($urandom_range(4, 10)) begin
               if ($urandom_range(1)) load_entry($urandom, $urandom, $urandom, $urandom,
                                                 $urandom, $urandom);
               else eval_fraction($urandom);
               sent++;
            end
         end
      end
   endtask

   initial begin
      logic [4:0] counts[6];
      logic [17:0] x;
      logic [19:0] ang;
      longint k;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty table, then a table full of corner cases.
      eval_fraction(32'h8000_0000);
      eval_fraction(32'h7fff_ffff);
      for (int i = 0; i < 16; i++) begin
         k = (i - 8) * 262144;
         if (i == 0) k = -2147483648 + 65536;
         if (i == 5) k = (4 - 8) * 262144;            // zero-length segment
         if (i == 15) k = 2147483646;
         ang = 20'($urandom_range(1, 300000));
         x = $urandom;
         case (i)
            0:  ang = 20'h80000;                       // most negative angle
            2:  ang = 20'd0;                           // zero angle at second end
            6:  x = 18'sd65536;
            7:  x = -18'sd131072;                      // negative dot, saturates
            8:  ang = 20'd10;
            9:  ang = 20'd400000;                      // shortest way wraps
            15: ang = 20'h7ffff;
            default: ;
         endcase
         if (i == 6 || i == 7)
            load_entry(i, k[31:0], x, 18'd0, 18'd0, ang);
         else
            load_entry(i, k[31:0], x, $urandom, $urandom, ang);
      end
      write_key_count(5'd16);
      eval_fraction(32'h8000_0000);
      eval_fraction(32'h7fff_ffff);
      eval_fraction(32'((7 - 8) * 262144));
      eval_fraction(32'((1 - 8) * 262144 + 131072));
      eval_fraction(32'((2 - 8) * 262144 + 131072));
      eval_fraction(32'((4 - 8) * 262144));
      eval_fraction(32'((8 - 8) * 262144 + 131072));

      // Random part in three idling modes, each over several key counts.
      for (int mode = 0; mode < 3; mode++) begin
         tx_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 83 : 0;
         rx_idle_pct = (mode == 0) ? 83 : (mode == 1) ? 32 : 0;
         counts = '{5'd1, 5'd2, 5'd16, 5'd31, 5'd0, 5'($urandom_range(3, 15))};
         foreach (counts[c]) run_phase(counts[c], 75);
      end
      req_tvalid <= 1'b0;

      while (sb.pending_rot.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d loads, %0d evaluations (%0d results checked), %0d key count writes.",
               sb.loads, sb.evals, sb.checked, cfg_writes);
      if (sb.errors == 0 && sb.pending_rot.size() == 0)
         $display("keyframe_rotation_interpolator_tb: done, clean");
      else
         $display("keyframe_rotation_interpolator_tb: done, errors");
      $finish;
   end

endmodule
